@@ sv/tfa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfa_pkg: shared types and codes of the two-tier first-fit allocator
// Item and result layouts, operation and status codes, and the command and
// status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package tfa_pkg;

    localparam int SLOTS_DEF = 1024;
    localparam int FW        = 11;
    localparam logic [10:0] SIZE_RST = 11'd1024;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_PRIMARY = 2'd1,
        OP_SECOND  = 2'd2,
        OP_RELEASE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_MAP_A    = 3'd0,
        ST_MAP_B    = 3'd1,
        ST_REFUSED  = 3'd2,
        ST_RELEASED = 3'd3,
        ST_CLEARED  = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]    op;
        logic [FW-1:0] length;
        logic [FW-1:0] range_start;
        logic [FW-1:0] range_end;
    } item_t;

    typedef struct packed {
        logic [FW-1:0] position;
        logic [2:0]    status;
    } result_t;

    typedef struct packed {
        logic load;
        logic sweep_init;
        logic rel_init;
        logic scan_init;
        logic scan_run;
        logic mark_init;
        logic write_run;
        logic respond;
    } tfa_cmd_t;

    typedef struct packed {
        op_t  op;
        logic bad_len;
        logic rel_empty;
        logic scan_done;
        logic granted;
        logic write_last;
    } tfa_stat_t;

endpackage

@@ sv/two_tier_first_fit_interval_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_tier_first_fit_interval_allocator: first-fit allocator over two maps
// Primary requests search map A; secondary requests search A, then B.
// Releases and clears free slots in both maps.
//
// channel   signals                        handshake
// item      start, item                    taken when start && !busy
// result    done, result                   one-cycle strobe, no stall
// config    psel/penable/pwrite/paddr/...  APB write, pready tied high
//
// Scans walk one slot a cycle through the map memory read port; marking,
// release and clear write one slot a cycle. After reset a clearing pass
// runs with busy high. Results cannot be stalled; the next item is taken
// in the cycle its predecessor's result is shown.
// ----------------------------------------------------------------------------
module two_tier_first_fit_interval_allocator
    import tfa_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  item_t       item,
    output logic        busy,
    output logic        done,
    output result_t     result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    tfa_cmd_t    cmd;
    tfa_stat_t   stat;
    logic [10:0] size_reg;

    // Size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= SIZE_RST;
        else if (psel && penable && pwrite && paddr == 3'd0)
            size_reg <= pwdata[10:0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? {21'd0, size_reg} : 32'd0;

    tfa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    tfa_datapath #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .size   (size_reg),
        .stat   (stat),
        .done   (done),
        .result (result)
    );

endmodule

@@ sv/tfa_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfa_datapath: occupancy maps, slot walker and first-fit run tracker
// Both maps are one-bit memories addressed by slot. A walker steps one slot a
// cycle for scans and for range writes; run counters track free runs.
// ----------------------------------------------------------------------------
module tfa_datapath
    import tfa_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  tfa_cmd_t      cmd,
    input  item_t         item,
    input  logic [10:0]   size,
    output tfa_stat_t     stat,
    output logic          done,
    output result_t       result
);

    localparam int SW = $clog2(SLOTS + 2);
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic mem_a [SLOTS];
    logic mem_b [SLOTS];

    logic [1:0]    op_reg;
    logic [FW-1:0] len_reg, rs_reg, re_reg;
    logic [SW-1:0] n_reg, ptr_reg, hi_reg, rslot_reg, runa_reg, runb_reg;
    logic [SW-1:0] posa_reg, posb_reg;
    logic          fa_reg, fb_reg, rv_reg, wr_b_reg, fill_reg;
    logic          dat_a, dat_b;
    logic          done_reg;
    result_t       result_reg;

    logic [31:0]   size32, n32, len32, rs_c, re_c, pos_sel, hi_sel;
    logic          issue, bad_len;
    logic [SW-1:0] runa_next, runb_next;

    // Clamp the size register to the slot range
    always_comb
    begin
        size32 = 32'(size);
        if (size32 == 32'd0)
            n32 = 32'd1;
        else if (size32 > 32'(SLOTS))
            n32 = 32'(SLOTS);
        else
            n32 = size32;
    end

    // Clamp release ends, pick the granted start
    always_comb
    begin
        len32   = 32'(len_reg);
        rs_c    = (rs_reg == '0) ? 32'd1 : 32'(rs_reg);
        re_c    = (32'(re_reg) > 32'(n_reg)) ? 32'(n_reg) : 32'(re_reg);
        bad_len = (len32 == 32'd0) || (len32 > 32'(n_reg));
        pos_sel = fa_reg ? 32'(posa_reg) : 32'(posb_reg);
        hi_sel  = pos_sel + len32 - 32'd1;
    end

    assign issue = cmd.scan_run && (ptr_reg <= n_reg) && !fa_reg;

    // Extend free runs with the slot read last cycle
    assign runa_next = dat_a ? runa_reg + SW'(1) : '0;
    assign runb_next = dat_b ? runb_reg + SW'(1) : '0;

    // Map memories: one read or one write per cycle
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            dat_a <= mem_a[AW'(ptr_reg - SW'(1))];
            dat_b <= mem_b[AW'(ptr_reg - SW'(1))];
        end
        if (cmd.write_run)
        begin
            mem_a[AW'(ptr_reg - SW'(1))] <= fill_reg;
            if (wr_b_reg)
                mem_b[AW'(ptr_reg - SW'(1))] <= fill_reg;
        end
    end

    // Capture the item and the effective size
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= item.op;
            len_reg <= item.length;
            rs_reg  <= item.range_start;
            re_reg  <= item.range_end;
            n_reg   <= SW'(n32);
        end
    end

    // Walker and run tracker
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg <= 1'b0;
            fa_reg <= 1'b0;
            fb_reg <= 1'b0;
        end
        else
        begin
            if (cmd.sweep_init)
            begin
                ptr_reg  <= SW'(1);
                hi_reg   <= SW'(SLOTS);
                fill_reg <= 1'b1;
                wr_b_reg <= 1'b1;
            end
            else if (cmd.rel_init)
            begin
                ptr_reg  <= SW'(rs_c);
                hi_reg   <= SW'(re_c);
                fill_reg <= 1'b1;
                wr_b_reg <= 1'b1;
            end
            else if (cmd.mark_init)
            begin
                ptr_reg  <= SW'(pos_sel);
                hi_reg   <= SW'(hi_sel);
                fill_reg <= 1'b0;
                wr_b_reg <= (op_reg == OP_SECOND);
            end
            else if (cmd.scan_init)
            begin
                ptr_reg  <= SW'(1);
                rv_reg   <= 1'b0;
                fa_reg   <= 1'b0;
                fb_reg   <= 1'b0;
                runa_reg <= '0;
                runb_reg <= '0;
            end
            else if (cmd.write_run)
                ptr_reg <= ptr_reg + SW'(1);
            else if (cmd.scan_run)
            begin
                if (issue)
                    ptr_reg <= ptr_reg + SW'(1);
                rv_reg    <= issue;
                rslot_reg <= ptr_reg;
                if (rv_reg)
                begin
                    runa_reg <= runa_next;
                    runb_reg <= runb_next;
                    if (!fa_reg && 32'(runa_next) >= len32)
                    begin
                        fa_reg   <= 1'b1;
                        posa_reg <= SW'(32'(rslot_reg) - len32 + 32'd1);
                    end
                    if (!fb_reg && 32'(runb_next) >= len32)
                    begin
                        fb_reg   <= 1'b1;
                        posb_reg <= SW'(32'(rslot_reg) - len32 + 32'd1);
                    end
                end
            end
        end
    end

    // Form and strobe the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.respond;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.respond)
        begin
            unique case (op_t'(op_reg))
                OP_CLEAR:
                begin
                    result_reg.position <= '0;
                    result_reg.status   <= ST_CLEARED;
                end
                OP_RELEASE:
                begin
                    result_reg.position <= '0;
                    result_reg.status   <= ST_RELEASED;
                end
                OP_PRIMARY, OP_SECOND:
                begin
                    priority if (bad_len)
                    begin
                        result_reg.position <= '0;
                        result_reg.status   <= ST_REFUSED;
                    end
                    else if (fa_reg)
                    begin
                        result_reg.status   <= ST_MAP_A;
                        result_reg.position <= FW'(posa_reg);
                    end
                    else if (op_reg == OP_SECOND && fb_reg)
                    begin
                        result_reg.status   <= ST_MAP_B;
                        result_reg.position <= FW'(posb_reg);
                    end
                    else
                    begin
                        result_reg.position <= '0;
                        result_reg.status   <= ST_REFUSED;
                    end
                end
                default:
                begin
                    result_reg.position <= '0;
                    result_reg.status   <= ST_REFUSED;
                end
            endcase
        end
    end

    assign stat.op         = op_t'(op_reg);
    assign stat.bad_len    = bad_len;
    assign stat.rel_empty  = rs_c > re_c;
    assign stat.scan_done  = fa_reg || ((ptr_reg > n_reg) && !rv_reg);
    assign stat.granted    = fa_reg || ((op_reg == OP_SECOND) && fb_reg);
    assign stat.write_last = (ptr_reg == hi_reg);

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ sv/tfa_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfa_ctrl: sequencer of the allocator
// Runs the clearing pass after reset, then steps each item through setup,
// scan (requests of valid length only), range write (if any) and response.
// ----------------------------------------------------------------------------
module tfa_ctrl
    import tfa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  tfa_stat_t stat,
    output tfa_cmd_t  cmd,
    output logic      busy
);

    typedef enum logic [6:0] {
        S_BOOT  = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_SETUP = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_PICK  = 7'b0010000,
        S_FILL  = 7'b0100000,
        S_RESP  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   item_reg, item_next;

    // Hold state and whether a fill belongs to an item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_BOOT;
            item_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            item_reg  <= item_next;
        end
    end

    // Advance the sequence
    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        cmd        = '0;
        unique case (state_reg)
            S_BOOT:
            begin
                cmd.sweep_init = 1'b1;
                item_next      = 1'b0;
                state_next     = S_FILL;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    item_next  = 1'b1;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                unique case (stat.op)
                    OP_CLEAR:
                    begin
                        cmd.sweep_init = 1'b1;
                        state_next     = S_FILL;
                    end
                    OP_RELEASE:
                    begin
                        cmd.rel_init = 1'b1;
                        state_next   = stat.rel_empty ? S_RESP : S_FILL;
                    end
                    default:
                    begin
                        if (stat.bad_len)
                            state_next = S_RESP;
                        else
                        begin
                            cmd.scan_init = 1'b1;
                            state_next    = S_SCAN;
                        end
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (stat.scan_done)
                    state_next = S_PICK;
            end
            S_PICK:
            begin
                if (stat.granted)
                begin
                    cmd.mark_init = 1'b1;
                    state_next    = S_FILL;
                end
                else
                    state_next = S_RESP;
            end
            S_FILL:
            begin
                cmd.write_run = 1'b1;
                if (stat.write_last)
                    state_next = item_reg ? S_RESP : S_IDLE;
            end
            S_RESP:
            begin
                cmd.respond = 1'b1;
                state_next  = S_IDLE;
            end
            default: state_next = S_BOOT;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

@@ sv/tfa_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfa_props: port-level checks of the allocator
// Watches the item and result ports over time.
// ----------------------------------------------------------------------------
module tfa_props
    import tfa_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    done,
    input result_t result
);

    // An accepted item keeps the block busy next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but block not busy");

    // A result is shown with the block ready for the next item
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while busy");

    // Strobes are single cycles
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // Non-grant results carry no position
    a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_MAP_A && result.status != ST_MAP_B)
            |-> (result.position == '0))
        else $error("position set on a non-grant result");

endmodule

bind two_tier_first_fit_interval_allocator tfa_props u_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
